/* sv/dercmp_pkg.sv */
package dercmp_pkg;

	localparam int ENV_W      = 40;
	localparam int MUL_W      = 32;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int Q_FRAC     = 30;
	localparam int FRAC_BITS  = 16;
	localparam int LOG_INT_W  = 6;
	localparam int LOG_W      = LOG_INT_W + FRAC_BITS;
	localparam int STR_W      = 16;
	localparam int STR_FRAC   = 12;
	localparam int GAIN_W     = 20;
	localparam int GAIN_FRAC  = 16;
	localparam int NORM_STEPS = 6;
	localparam int CFG_IDX_W  = 2;

	localparam logic [MUL_W-1:0]  Q30_ONE   = MUL_W'(1) << Q_FRAC;
	localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1) << GAIN_FRAC;
	localparam logic [GAIN_W-1:0] GAIN_MAX  = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_FAST = 2'd0,
		REG_COEF_SLOW = 2'd1,
		REG_STRENGTH  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_op_t;

	typedef logic [FRAC_BITS-1:0][MUL_W-1:0] root_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bt;
		rem = v;
		res = '0;
		bt  = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bt) begin
				rem = rem - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// Entry k holds 2^(2^-(k+1)) in Q1.30, each one the truncated root of the one before.
	function automatic root_tab_t make_roots();
		root_tab_t   t;
		logic [63:0] r;
		r = 64'(Q30_ONE) << 1;
		for (int k = 0; k < FRAC_BITS; k++) begin
			r    = isqrt64(r << Q_FRAC);
			t[k] = r[MUL_W-1:0];
		end
		return t;
	endfunction

	localparam root_tab_t ROOTS = make_roots();

endpackage

/* sv/dual_envelope_relative_compressor.sv */
// Dual-envelope relative compressor.
// Input channel (in_valid/in_ready/sample_in) takes one signed sample per transaction.
// Output channel (out_valid/out_ready/sample_out) returns one gain-scaled, saturated
// sample per input, in order. The configuration channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) writes coef_fast (0), coef_slow (1) and strength (2); other
// indexes are ignored. It is always ready and is meant to be used between samples.
// Each sample runs through one shared 32x32 multiplier under a sequencer: two
// envelope updates, two 16-step log2 squaring loops, the strength product, a
// 16-step exp2 loop and the gain product. The log2 and exp2 loops are skipped while
// either envelope is zero, and the exp2 loop when the gain saturates high. A new
// sample can be taken in the cycle after the previous result is loaded into the
// output register, so the block works on one sample at a time.
// The output register holds a finished result while the receiver stalls, and the
// block keeps taking the next sample; that sample then waits at its end until the
// register is free. Reset clears both envelopes and loads the register defaults.
module dual_envelope_relative_compressor #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [SAMPLE_BITS-1:0]     sample_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [SAMPLE_BITS-1:0]     sample_out,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dercmp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [COEF_BITS-1:0]              cfg_data
);
	import dercmp_pkg::*;

	logic [COEF_BITS-1:0]          coef_fast_q;
	logic [COEF_BITS-1:0]          coef_slow_q;
	logic signed [STR_W-1:0]       strength_q;
	mul_op_t                       mul_op;
	logic [PROD_W-1:0]             mul_p;
	logic                          res_valid;
	logic                          res_ready;
	logic signed [SAMPLE_BITS-1:0] res_sample;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;

	dercmp_cfg #(
		.COEF_BITS (COEF_BITS)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.coef_fast_q (coef_fast_q),
		.coef_slow_q (coef_slow_q),
		.strength_q  (strength_q)
	);

	dercmp_mul u_mul (
		.clk (clk),
		.op  (mul_op),
		.p_q (mul_p)
	);

	dercmp_core #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample_in),
		.coef_fast  (coef_fast_q),
		.coef_slow  (coef_slow_q),
		.strength   (strength_q),
		.mul_op     (mul_op),
		.mul_p      (mul_p),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_sample (res_sample)
	);

	assign res_ready  = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			sample_out_q <= '0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				sample_out_q <= res_sample;
			end
		end
	end

endmodule

/* sv/dercmp_cfg.sv */
module dercmp_cfg #(
	parameter int COEF_BITS = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [dercmp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [COEF_BITS-1:0]                   cfg_data,
	output logic [COEF_BITS-1:0]                   coef_fast_q,
	output logic [COEF_BITS-1:0]                   coef_slow_q,
	output logic signed [dercmp_pkg::STR_W-1:0]    strength_q
);
	import dercmp_pkg::*;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_fast_q <= COEF_BITS'(32'd345600);
			coef_slow_q <= COEF_BITS'(32'd3495);
			strength_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COEF_FAST: coef_fast_q <= cfg_data;
				REG_COEF_SLOW: coef_slow_q <= cfg_data;
				REG_STRENGTH:  strength_q  <= cfg_data[STR_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

/* sv/dercmp_mul.sv */
module dercmp_mul (
	input  logic                              clk,
	input  dercmp_pkg::mul_op_t               op,
	output logic [dercmp_pkg::PROD_W-1:0]     p_q
);
	import dercmp_pkg::*;

	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(op.a) * PROD_W'(op.b);

	always_ff @(posedge clk) begin
		p_q <= prod;
	end

endmodule

/* sv/dercmp_core.sv */
module dercmp_core #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  logic [COEF_BITS-1:0]                coef_fast,
	input  logic [COEF_BITS-1:0]                coef_slow,
	input  logic signed [dercmp_pkg::STR_W-1:0] strength,
	output dercmp_pkg::mul_op_t                 mul_op,
	input  logic [dercmp_pkg::PROD_W-1:0]       mul_p,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic signed [SAMPLE_BITS-1:0]       res_sample
);
	import dercmp_pkg::*;

	localparam int ENV_SHIFT = ENV_W - SAMPLE_BITS;
	localparam int TOT_W     = 72;
	localparam int LD_W      = LOG_W + 1;
	localparam int EP_W      = STR_W + LD_W;
	localparam int EM_W      = EP_W + 1 - STR_FRAC;
	localparam int IP_W      = EM_W - FRAC_BITS;
	localparam int YP_W      = SAMPLE_BITS + GAIN_W + 1;
	localparam int YQ_W      = YP_W - GAIN_FRAC;
	localparam int CNT_W     = 5;

	typedef enum logic [4:0] {
		S_IDLE, S_ENV_D, S_ENV_LO, S_ENV_HI, S_ENV_STEP, S_ENV_UPD, S_ZCHK,
		S_NORM, S_SQR, S_LOGEND, S_EMUL, S_ESET, S_EXP, S_GAIN, S_YMUL, S_YSAT, S_DONE
	} state_t;

	state_t                        state_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [SAMPLE_BITS-1:0]        mag_q;
	logic [ENV_W-1:0]              env_fast_q;
	logic [ENV_W-1:0]              env_slow_q;
	logic                          env_sel_q;
	logic                          up_q;
	logic [ENV_W-1:0]              d_q;
	logic [PROD_W-1:0]             lo_q;
	logic [ENV_W-1:0]              step_q;
	logic [ENV_W-1:0]              nv_q;
	logic [LOG_INT_W-1:0]          nsh_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [FRAC_BITS-1:0]          frac_q;
	logic                          log_sel_q;
	logic [LOG_W-1:0]              lslow_q;
	logic signed [LD_W-1:0]        ldiff_q;
	logic                          eneg_q;
	logic signed [IP_W-1:0]        ip_q;
	logic [FRAC_BITS-1:0]          fp_q;
	logic [MUL_W-1:0]              m_q;
	logic [GAIN_W-1:0]             gain_q;
	logic signed [SAMPLE_BITS-1:0] y_q;

	logic [SAMPLE_BITS-1:0] mag_in;
	logic [ENV_W-1:0]       env_cur;
	logic [COEF_BITS-1:0]   coef_cur;
	logic [ENV_W-1:0]       xs;
	logic                   xs_up;
	logic [TOT_W-1:0]       env_total;
	logic [ENV_W-1:0]       env_next;
	logic                   nrm_hit;
	logic [LOG_INT_W-1:0]   nrm_amt;
	logic [ENV_W-1:0]       nrm_shift;
	logic [MUL_W-1:0]       prod_m;
	logic                   sq_bit;
	logic [MUL_W-1:0]       sq_next;
	logic [MUL_W-1:0]       sq_in;
	logic [LOG_W-1:0]       logv;
	logic signed [LD_W-1:0] ldiff;
	logic [STR_W-1:0]       str_mag;
	logic [LD_W-1:0]        l_mag;
	logic [EP_W:0]          e_sum;
	logic [EM_W-1:0]        e_mag;
	logic signed [EM_W-1:0] e_s;
	logic signed [IP_W-1:0] ip_v;
	logic [4:0]             gsh;
	logic [MUL_W-1:0]       g_full;
	logic [GAIN_W-1:0]      gain_v;
	logic                   yneg;
	logic [YP_W-1:0]        yp;
	logic [YQ_W-1:0]        yq;
	logic [YQ_W-1:0]        ylim;
	logic [SAMPLE_BITS-1:0] y_v;

	assign mag_in    = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
	assign env_cur   = env_sel_q ? env_slow_q : env_fast_q;
	assign coef_cur  = env_sel_q ? coef_slow : coef_fast;
	assign xs        = {mag_q, {ENV_SHIFT{1'b0}}};
	assign xs_up     = xs >= env_cur;
	// Step is coef * d over 2^COEF_BITS, built from the low and high partial products of d.
	assign env_total = TOT_W'(lo_q) + {mul_p[ENV_W-1:0], {MUL_W{1'b0}}};
	assign env_next  = up_q ? env_cur + step_q : env_cur - step_q;

	always_comb begin
		nrm_hit   = 1'b0;
		nrm_amt   = '0;
		nrm_shift = nv_q;
		unique case (cnt_q)
			5'd0: begin
				nrm_hit = ~|nv_q[39:8];
				nrm_amt = 6'd32;
				nrm_shift = nv_q << 32;
			end
			5'd1: begin
				nrm_hit = ~|nv_q[39:24];
				nrm_amt = 6'd16;
				nrm_shift = nv_q << 16;
			end
			5'd2: begin
				nrm_hit = ~|nv_q[39:32];
				nrm_amt = 6'd8;
				nrm_shift = nv_q << 8;
			end
			5'd3: begin
				nrm_hit = ~|nv_q[39:36];
				nrm_amt = 6'd4;
				nrm_shift = nv_q << 4;
			end
			5'd4: begin
				nrm_hit = ~|nv_q[39:38];
				nrm_amt = 6'd2;
				nrm_shift = nv_q << 2;
			end
			5'd5: begin
				nrm_hit = ~nv_q[39];
				nrm_amt = 6'd1;
				nrm_shift = nv_q << 1;
			end
			default: begin
			end
		endcase
	end

	assign prod_m  = mul_p[Q_FRAC +: MUL_W];
	assign sq_bit  = prod_m[MUL_W-1];
	assign sq_next = sq_bit ? {1'b0, prod_m[MUL_W-1:1]} : prod_m;
	assign sq_in   = (cnt_q == '0) ? MUL_W'(nv_q[ENV_W-1:ENV_W-1-Q_FRAC]) : sq_next;
	assign logv    = {LOG_INT_W'(6'd39 - nsh_q), frac_q};
	assign ldiff   = signed'({1'b0, lslow_q}) - signed'({1'b0, logv});
	assign str_mag = strength[STR_W-1] ? (~strength + 1'b1) : strength;
	assign l_mag   = ldiff_q[LD_W-1] ? (~ldiff_q + 1'b1) : ldiff_q;

	// Floor of the signed product over 2^12: a negative product rounds its magnitude up.
	assign e_sum = {1'b0, mul_p[EP_W-1:0]} + (eneg_q ? (EP_W+1)'(12'hFFF) : '0);
	assign e_mag = e_sum[EP_W:STR_FRAC];
	assign e_s   = eneg_q ? -signed'(e_mag) : signed'(e_mag);
	assign ip_v  = e_s[EM_W-1:FRAC_BITS];

	assign gsh    = 5'(IP_W'(14) - ip_q);
	assign g_full = m_q >> gsh;
	assign gain_v = (g_full > MUL_W'(GAIN_MAX)) ? GAIN_MAX : g_full[GAIN_W-1:0];

	assign yneg = x_q[SAMPLE_BITS-1];
	assign yp   = mul_p[YP_W-1:0] + (yneg ? YP_W'(16'hFFFF) : '0);
	assign yq   = yp[YP_W-1:GAIN_FRAC];
	assign ylim = yneg ? (YQ_W'(1) << (SAMPLE_BITS - 1))
	                   : ((YQ_W'(1) << (SAMPLE_BITS - 1)) - 1'b1);

	always_comb begin
		if (yq > ylim) begin
			y_v = yneg ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else if (yneg) begin
			y_v = ~yq[SAMPLE_BITS-1:0] + 1'b1;
		end else begin
			y_v = yq[SAMPLE_BITS-1:0];
		end
	end

	always_comb begin
		mul_op = '0;
		unique case (state_q)
			S_ENV_LO: begin
				mul_op.a = MUL_W'(coef_cur);
				mul_op.b = d_q[MUL_W-1:0];
			end
			S_ENV_HI: begin
				mul_op.a = MUL_W'(coef_cur);
				mul_op.b = MUL_W'(d_q[ENV_W-1:MUL_W]);
			end
			S_SQR: begin
				mul_op.a = sq_in;
				mul_op.b = sq_in;
			end
			S_EMUL: begin
				mul_op.a = MUL_W'(str_mag);
				mul_op.b = MUL_W'(l_mag);
			end
			S_EXP: begin
				mul_op.a = (cnt_q == '0) ? Q30_ONE : prod_m;
				mul_op.b = fp_q[FRAC_BITS-1] ? ROOTS[cnt_q[3:0]] : Q30_ONE;
			end
			S_YMUL: begin
				mul_op.a = MUL_W'(mag_q);
				mul_op.b = MUL_W'(gain_q);
			end
			default: begin
			end
		endcase
	end

	assign in_ready   = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign res_sample = y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			x_q        <= '0;
			mag_q      <= '0;
			env_fast_q <= '0;
			env_slow_q <= '0;
			env_sel_q  <= 1'b0;
			up_q       <= 1'b0;
			d_q        <= '0;
			lo_q       <= '0;
			step_q     <= '0;
			nv_q       <= '0;
			nsh_q      <= '0;
			cnt_q      <= '0;
			frac_q     <= '0;
			log_sel_q  <= 1'b0;
			lslow_q    <= '0;
			ldiff_q    <= '0;
			eneg_q     <= 1'b0;
			ip_q       <= '0;
			fp_q       <= '0;
			m_q        <= '0;
			gain_q     <= '0;
			y_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						x_q       <= sample;
						mag_q     <= mag_in;
						env_sel_q <= 1'b0;
						state_q   <= S_ENV_D;
					end
				end
				S_ENV_D: begin
					up_q    <= xs_up;
					d_q     <= xs_up ? xs - env_cur : env_cur - xs;
					state_q <= S_ENV_LO;
				end
				S_ENV_LO: begin
					state_q <= S_ENV_HI;
				end
				S_ENV_HI: begin
					lo_q    <= mul_p;
					state_q <= S_ENV_STEP;
				end
				S_ENV_STEP: begin
					step_q  <= env_total[COEF_BITS +: ENV_W];
					state_q <= S_ENV_UPD;
				end
				S_ENV_UPD: begin
					if (env_sel_q) begin
						env_slow_q <= env_next;
						state_q    <= S_ZCHK;
					end else begin
						env_fast_q <= env_next;
						env_sel_q  <= 1'b1;
						state_q    <= S_ENV_D;
					end
				end
				S_ZCHK: begin
					if (env_fast_q == '0 || env_slow_q == '0) begin
						gain_q  <= GAIN_ONE;
						state_q <= S_YMUL;
					end else begin
						log_sel_q <= 1'b1;
						nv_q      <= env_slow_q;
						nsh_q     <= '0;
						cnt_q     <= '0;
						state_q   <= S_NORM;
					end
				end
				S_NORM: begin
					if (nrm_hit) begin
						nv_q  <= nrm_shift;
						nsh_q <= nsh_q + nrm_amt;
					end
					if (cnt_q == CNT_W'(NORM_STEPS - 1)) begin
						cnt_q   <= '0;
						frac_q  <= '0;
						state_q <= S_SQR;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SQR: begin
					if (cnt_q != '0) begin
						frac_q <= {frac_q[FRAC_BITS-2:0], sq_bit};
					end
					if (cnt_q == CNT_W'(FRAC_BITS)) begin
						cnt_q   <= '0;
						state_q <= S_LOGEND;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_LOGEND: begin
					if (log_sel_q) begin
						lslow_q   <= logv;
						log_sel_q <= 1'b0;
						nv_q      <= env_fast_q;
						nsh_q     <= '0;
						cnt_q     <= '0;
						state_q   <= S_NORM;
					end else begin
						ldiff_q <= ldiff;
						state_q <= S_EMUL;
					end
				end
				S_EMUL: begin
					eneg_q  <= strength[STR_W-1] ^ ldiff_q[LD_W-1];
					state_q <= S_ESET;
				end
				S_ESET: begin
					ip_q  <= ip_v;
					fp_q  <= e_s[FRAC_BITS-1:0];
					cnt_q <= '0;
					if (ip_v > IP_W'(3)) begin
						gain_q  <= GAIN_MAX;
						state_q <= S_YMUL;
					end else begin
						state_q <= S_EXP;
					end
				end
				S_EXP: begin
					fp_q <= fp_q << 1;
					if (cnt_q == CNT_W'(FRAC_BITS)) begin
						m_q     <= prod_m;
						cnt_q   <= '0;
						state_q <= S_GAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_GAIN: begin
					// Below 2^-16 the shift would exceed the mantissa width.
					gain_q  <= (ip_q < -IP_W'(16)) ? '0 : gain_v;
					state_q <= S_YMUL;
				end
				S_YMUL: begin
					state_q <= S_YSAT;
				end
				S_YSAT: begin
					y_q     <= y_v;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ENV_UPD) |-> (step_q <= d_q))
		else $error("envelope step exceeds distance to target");

	a_norm_top: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQR && cnt_q == '0) |-> nv_q[ENV_W-1])
		else $error("log2 normalization left top bit clear");

	a_sqr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQR && cnt_q != '0) |-> (mul_p[PROD_W-1:Q_FRAC+MUL_W] == '0))
		else $error("log2 square out of range");

	a_exp_mant: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GAIN) |-> (m_q[MUL_W-1:Q_FRAC] == 2'b01))
		else $error("exp2 mantissa outside [1,2)");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (!in_ready && !res_valid))
		else $error("core not busy after taking a sample");

endmodule
